/* hdl/hts_pkg.sv */
`default_nettype none
package hts_pkg;

  localparam int HTS_FRAC_BITS = 16;
  localparam int CFG_AW        = 4;
  localparam int REG_W         = 18;
  localparam int DIV_W         = 11;

  localparam logic [1:0] REG_HUE = 2'd0;
  localparam logic [1:0] REG_SAT = 2'd1;
  localparam logic [1:0] REG_LIT = 2'd2;

  localparam logic [16:0] REG_MAX = 17'h10000;

  typedef struct packed {
    logic        hue_en;
    logic [16:0] hue_v;
    logic        sat_en;
    logic [16:0] sat_v;
    logic        lit_en;
    logic [16:0] lit_v;
  } hts_cfg_t;

endpackage
`default_nettype wire

/* hdl/hts_in_if.sv */
`default_nettype none
interface hts_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_in;
  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface
`default_nettype wire

/* hdl/hts_out_if.sv */
`default_nettype none
interface hts_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_out;
  modport source (output valid, output pixel_out, input ready);
  modport sink (input valid, input pixel_out, output ready);
endinterface
`default_nettype wire

/* hdl/hts_cfg.sv */
`default_nettype none
module hts_cfg import hts_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output hts_cfg_t               cfg
);

  logic [REG_W-1:0] hue_r, sat_r, lit_r;
  logic [1:0]       idx;
  logic             wr;

  function automatic logic [16:0] clamp_v(input logic [REG_W-1:0] raw);
    return (raw[16:0] > REG_MAX) ? REG_MAX : raw[16:0];
  endfunction

  assign idx    = paddr[3:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_r <= '1;
      sat_r <= '1;
      lit_r <= '1;
    end else if (wr) begin
      case (idx)
        REG_HUE: hue_r <= pwdata[REG_W-1:0];
        REG_SAT: sat_r <= pwdata[REG_W-1:0];
        REG_LIT: lit_r <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_HUE: prdata = {{(32-REG_W){hue_r[REG_W-1]}}, hue_r};
      REG_SAT: prdata = {{(32-REG_W){sat_r[REG_W-1]}}, sat_r};
      REG_LIT: prdata = {{(32-REG_W){lit_r[REG_W-1]}}, lit_r};
      default: prdata = '0;
    endcase
  end

  assign cfg.hue_en = ~hue_r[REG_W-1];
  assign cfg.hue_v  = clamp_v(hue_r);
  assign cfg.sat_en = ~sat_r[REG_W-1];
  assign cfg.sat_v  = clamp_v(sat_r);
  assign cfg.lit_en = ~lit_r[REG_W-1];
  assign cfg.lit_v  = clamp_v(lit_r);

endmodule
`default_nettype wire

/* hdl/hts_div.sv */
`default_nettype none
// one quotient bit per stage; requires a < 2*dv
module hts_div #(
  parameter int DW = 11,
  parameter int QW = 17
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [DW-1:0] a,
  input  wire logic [DW-1:0] dv,
  output logic      [QW-1:0] q
);

  logic [DW-1:0] rem_r [QW-1];
  logic [DW-1:0] dv_r  [QW-1];
  logic [QW-1:0] q_r   [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW:0]   cand;
    logic [DW-1:0] dvi;
    logic          ge;
    logic [DW:0]   diff;
    logic [QW-1:0] q_nxt;

    if (i == 0) begin : g_first
      assign cand  = {1'b0, a};
      assign dvi   = dv;
      assign q_nxt = {{(QW-1){1'b0}}, ge};
    end else begin : g_next
      assign cand  = {rem_r[i-1], 1'b0};
      assign dvi   = dv_r[i-1];
      assign q_nxt = {q_r[i-1][QW-2:0], ge};
    end

    assign ge   = cand >= {1'b0, dvi};
    assign diff = cand - {1'b0, dvi};

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i] <= q_nxt;
      end
    end

    if (i < QW-1) begin : g_rem
      logic [DW-1:0] rem_nxt;
      assign rem_nxt = ge ? diff[DW-1:0] : cand[DW-1:0];
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= rem_nxt;
          dv_r[i]  <= dvi;
        end
      end
    end
  end

  assign q = q_r[QW-1];

endmodule
`default_nettype wire

/* hdl/hts_back.sv */
`default_nettype none
module hts_back import hts_pkg::*; #(
  parameter int FRAC_BITS = HTS_FRAC_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_v,
  input  wire logic [FRAC_BITS:0] h_q,
  input  wire logic [FRAC_BITS:0] s_q,
  input  wire logic [FRAC_BITS:0] l_q,
  input  wire logic             dz,
  input  wire logic [7:0]       alpha,
  input  wire hts_cfg_t         cfg,
  output logic                  out_v,
  output logic      [31:0]      pixel
);

  localparam int F = FRAC_BITS;
  localparam int W = F + 1;
  localparam logic [F:0]   ONE   = W'(1) << F;
  localparam logic [F:0]   HALF  = W'(1) << (F-1);
  localparam logic [F+2:0] ONE_X = (F+3)'(1) << F;
  localparam logic [F+2:0] TWO_X = (F+3)'(2) << F;
  localparam logic [F+2:0] X3    = (F+3)'(3) << F;
  localparam logic [F+3:0] ONE_Y = (F+4)'(1) << F;
  localparam logic [F+3:0] Y3    = (F+4)'(3) << F;
  localparam logic [F+3:0] Y4    = (F+4)'(4) << F;

  localparam logic [1:0] SEG_RISE = 2'd0;
  localparam logic [1:0] SEG_TOP  = 2'd1;
  localparam logic [1:0] SEG_FALL = 2'd2;
  localparam logic [1:0] SEG_BOT  = 2'd3;

  function automatic logic [F:0] conv(input logic [16:0] v);
    logic [F+16:0] t;
    t = {v, {F{1'b0}}};
    return t[F+16:16];
  endfunction

  // ---- stage 1: hue select, saturation operands
  logic [F:0] hsh, ssh, h1, s1, ksat;
  logic [F+1:0] ksat_w;
  logic       lo_s;
  logic       p1_v_r, p1_se_r, p1_lo_r;
  logic [F:0] p1_h_r, p1_s_r, p1_l_r, p1_ma_r, p1_mb_r;
  logic [F:0] p1_ma_nxt, p1_mb_nxt;
  logic [7:0] p1_a_r;

  assign hsh    = conv(cfg.hue_v);
  assign ssh    = conv(cfg.sat_v);
  assign h1     = cfg.hue_en ? hsh : (dz ? '0 : h_q);
  assign s1     = dz ? '0 : s_q;
  assign lo_s   = ssh <= HALF;
  assign ksat_w = {ssh, 1'b0} - {1'b0, ONE};
  assign ksat   = ksat_w[F:0];
  assign p1_ma_nxt = lo_s ? s1 : ONE - s1;
  assign p1_mb_nxt = lo_s ? ssh : ksat;

  // ---- stage 2: saturation product
  logic           p2_v_r, p2_se_r, p2_lo_r;
  logic [F:0]     p2_h_r, p2_s_r, p2_l_r;
  logic [7:0]     p2_a_r;
  logic [2*W-1:0] p2_prod_r, p2_prod_nxt;
  assign p2_prod_nxt = p1_ma_r * p1_mb_r;

  // ---- stage 3: new saturation, t2 operand
  logic [F:0]   s2_nxt;
  logic         lo_l_nxt;
  logic [F+1:0] tb_nxt;
  logic         p3_v_r, p3_lo_r;
  logic [F:0]   p3_h_r, p3_s_r, p3_l_r;
  logic [F+1:0] p3_tb_r;
  logic [7:0]   p3_a_r;

  always_comb begin
    if (!p2_se_r) begin
      s2_nxt = p2_s_r;
    end else if (p2_lo_r) begin
      s2_nxt = p2_prod_r[2*F-1:F-1];
    end else begin
      s2_nxt = p2_s_r + p2_prod_r[2*F:F];
    end
  end
  assign lo_l_nxt = p2_l_r < HALF;
  assign tb_nxt   = lo_l_nxt ? ({1'b0, ONE} + {1'b0, s2_nxt}) : {1'b0, s2_nxt};

  // ---- stage 4: l product
  logic           p4_v_r, p4_lo_r;
  logic [F:0]     p4_h_r, p4_s_r, p4_l_r;
  logic [7:0]     p4_a_r;
  logic [2*F+2:0] p4_tp_r, p4_tp_nxt;
  assign p4_tp_nxt = p3_l_r * p3_tb_r;

  // ---- stage 5: t1/t2, channel segments
  logic [F+1:0] t2_w, t1_w;
  logic [F:0]   tpf, t2_nxt, t1_nxt, d21_nxt;
  logic [F+2:0] h3, xr0;
  logic [F+2:0] xc [3];
  logic [1:0]   seg_nxt [3];
  logic [F:0]   fac_nxt [3];
  logic [7:0]   gval_nxt;
  logic         p5_v_r, p5_grey_r;
  logic [F:0]   p5_t1_r, p5_t2_r, p5_d21_r;
  logic [1:0]   p5_seg_r [3];
  logic [F:0]   p5_fac_r [3];
  logic [7:0]   p5_gval_r, p5_a_r;

  assign tpf    = p4_tp_r[2*F:F];
  assign t2_w   = p4_lo_r ? {1'b0, tpf} : ({1'b0, p4_l_r} + {1'b0, p4_s_r} - {1'b0, tpf});
  assign t2_nxt = t2_w[F:0];
  assign t1_w   = {p4_l_r, 1'b0} - t2_w;
  assign t1_nxt = t1_w[F:0];
  assign d21_nxt = t2_nxt - t1_nxt;
  assign gval_nxt = p4_l_r[F] ? 8'hFF : p4_l_r[F-1:F-8];
  assign h3     = ({2'b0, p4_h_r} << 1) + {2'b0, p4_h_r};
  assign xr0    = h3 + ONE_X;
  assign xc[0]  = (xr0 > X3) ? xr0 - X3 : xr0;
  assign xc[1]  = h3;
  assign xc[2]  = (h3 < ONE_X) ? h3 + TWO_X : h3 - ONE_X;

  always_comb begin
    logic [F+3:0] x2;
    logic [F+3:0] fall;
    for (int c = 0; c < 3; c++) begin
      x2   = {xc[c], 1'b0};
      fall = Y4 - x2;
      if (x2 < ONE_Y) begin
        seg_nxt[c] = SEG_RISE;
        fac_nxt[c] = x2[F:0];
      end else if (x2 < Y3) begin
        seg_nxt[c] = SEG_TOP;
        fac_nxt[c] = '0;
      end else if ({1'b0, xc[c]} < (ONE_Y << 1)) begin
        seg_nxt[c] = SEG_FALL;
        fac_nxt[c] = fall[F:0];
      end else begin
        seg_nxt[c] = SEG_BOT;
        fac_nxt[c] = '0;
      end
    end
  end

  // ---- stage 6: channel products
  logic           p6_v_r, p6_grey_r;
  logic [F:0]     p6_t1_r, p6_t2_r;
  logic [1:0]     p6_seg_r [3];
  logic [2*W-1:0] p6_prod_r [3];
  logic [7:0]     p6_gval_r, p6_a_r;

  // ---- stage 7: channel bytes, lightness operands
  logic [F:0]   lsh, klit, lk_nxt;
  logic [F+1:0] klit_w;
  logic         lo_lit;
  logic [7:0]   c_nxt [3];
  logic [7:0]   lm_nxt [3];
  logic         p7_v_r, p7_le_r, p7_lo_r;
  logic [7:0]   p7_c_r [3];
  logic [7:0]   p7_lm_r [3];
  logic [F:0]   p7_lk_r;
  logic [7:0]   p7_a_r;

  assign lsh    = conv(cfg.lit_v);
  assign lo_lit = lsh <= HALF;
  assign klit_w = {lsh, 1'b0} - {1'b0, ONE};
  assign klit   = klit_w[F:0];
  assign lk_nxt = lo_lit ? lsh : klit;

  always_comb begin
    logic [F:0]   v;
    logic [F+8:0] m;
    for (int c = 0; c < 3; c++) begin
      case (p6_seg_r[c])
        SEG_RISE, SEG_FALL: v = p6_t1_r + p6_prod_r[c][2*F:F];
        SEG_TOP:            v = p6_t2_r;
        default:            v = p6_t1_r;
      endcase
      m = {v, 8'b0} - {8'b0, v};
      c_nxt[c]  = p6_grey_r ? p6_gval_r : m[F+7:F];
      lm_nxt[c] = lo_lit ? c_nxt[c] : 8'hFF - c_nxt[c];
    end
  end

  // ---- stage 8: lightness products
  logic         p8_v_r, p8_le_r, p8_lo_r;
  logic [7:0]   p8_c_r [3];
  logic [F+8:0] p8_lp_r [3];
  logic [7:0]   p8_a_r;

  // ---- stage 9: output word
  logic [7:0]  o_nxt [3];
  logic        p9_v_r;
  logic [31:0] p9_pix_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (!p8_le_r) begin
        o_nxt[c] = p8_c_r[c];
      end else if (p8_lo_r) begin
        o_nxt[c] = p8_lp_r[c][F+6:F-1];
      end else begin
        o_nxt[c] = p8_c_r[c] + p8_lp_r[c][F+7:F];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
      p4_v_r <= 1'b0;
      p5_v_r <= 1'b0;
      p6_v_r <= 1'b0;
      p7_v_r <= 1'b0;
      p8_v_r <= 1'b0;
      p9_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r <= in_v;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
      p4_v_r <= p3_v_r;
      p5_v_r <= p4_v_r;
      p6_v_r <= p5_v_r;
      p7_v_r <= p6_v_r;
      p8_v_r <= p7_v_r;
      p9_v_r <= p8_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_h_r  <= h1;
      p1_s_r  <= s1;
      p1_l_r  <= l_q;
      p1_a_r  <= alpha;
      p1_ma_r <= p1_ma_nxt;
      p1_mb_r <= p1_mb_nxt;
      p1_se_r <= cfg.sat_en;
      p1_lo_r <= lo_s;

      p2_h_r    <= p1_h_r;
      p2_s_r    <= p1_s_r;
      p2_l_r    <= p1_l_r;
      p2_a_r    <= p1_a_r;
      p2_se_r   <= p1_se_r;
      p2_lo_r   <= p1_lo_r;
      p2_prod_r <= p2_prod_nxt;

      p3_h_r  <= p2_h_r;
      p3_s_r  <= s2_nxt;
      p3_l_r  <= p2_l_r;
      p3_a_r  <= p2_a_r;
      p3_lo_r <= lo_l_nxt;
      p3_tb_r <= tb_nxt;

      p4_h_r  <= p3_h_r;
      p4_s_r  <= p3_s_r;
      p4_l_r  <= p3_l_r;
      p4_a_r  <= p3_a_r;
      p4_lo_r <= p3_lo_r;
      p4_tp_r <= p4_tp_nxt;

      p5_t1_r   <= t1_nxt;
      p5_t2_r   <= t2_nxt;
      p5_d21_r  <= d21_nxt;
      p5_grey_r <= (p4_s_r == '0);
      p5_gval_r <= gval_nxt;
      p5_a_r    <= p4_a_r;

      p6_t1_r   <= p5_t1_r;
      p6_t2_r   <= p5_t2_r;
      p6_grey_r <= p5_grey_r;
      p6_gval_r <= p5_gval_r;
      p6_a_r    <= p5_a_r;

      p7_lk_r <= lk_nxt;
      p7_le_r <= cfg.lit_en;
      p7_lo_r <= lo_lit;
      p7_a_r  <= p6_a_r;

      p8_le_r <= p7_le_r;
      p8_lo_r <= p7_lo_r;
      p8_a_r  <= p7_a_r;

      p9_pix_r <= {p8_a_r, o_nxt[0], o_nxt[1], o_nxt[2]};

      for (int c = 0; c < 3; c++) begin
        p5_seg_r[c]  <= seg_nxt[c];
        p5_fac_r[c]  <= fac_nxt[c];
        p6_seg_r[c]  <= p5_seg_r[c];
        p6_prod_r[c] <= p5_d21_r * p5_fac_r[c];
        p7_c_r[c]    <= c_nxt[c];
        p7_lm_r[c]   <= lm_nxt[c];
        p8_c_r[c]    <= p7_c_r[c];
        p8_lp_r[c]   <= p7_lm_r[c] * p7_lk_r;
      end
    end
  end

  assign out_v = p9_v_r;
  assign pixel = p9_pix_r;

endmodule
`default_nettype wire

/* hdl/hsl_tint_shift_pixel.sv */
// HSL tint/shift of one ARGB8888 pixel per word.
// in_px  : sink channel, valid/ready, pixel_in (A 31:24, R 23:16, G 15:8, B 7:0).
// out_px : source channel, valid/ready, pixel_out in the same packing, A copied.
// APB port: hue_target at 0x0, saturation_shift at 0x4, lightness_shift at 0x8,
//   18-bit two's complement, negative disables; reads return sign-extended value.
// Pipeline: the input register, the two one-bit-per-stage dividers (saturation,
//   hue) running side by side and nine arithmetic stages behind them.
// Throughput: one word per cycle while out_px.ready does not hold the pipeline.
// Reset (rst_n low, synchronous): pipeline emptied, all three registers read -1.
// When out_px.ready is low with a word waiting, the whole pipeline holds and
//   in_px.ready drops in the same cycle; nothing is lost or repeated.
// Write registers only while no word is in flight.
`default_nettype none
module hsl_tint_shift_pixel import hts_pkg::*; #(
  parameter int FRAC_BITS = HTS_FRAC_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  hts_in_if.sink                 in_px,
  hts_out_if.source              out_px,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  localparam int QW = FRAC_BITS + 1;

  hts_cfg_t cfg;
  logic     en, out_v;

  hts_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  assign en          = ~out_v | out_px.ready;
  assign in_px.ready = en;

  // front: max/min, divider operands
  logic [7:0]       r, g, b, mx, mn, d;
  logic [8:0]       sum, sden;
  logic             dz;
  logic signed [11:0] n0, n1;
  logic [DIV_W-1:0] d6;

  assign r   = in_px.pixel_in[23:16];
  assign g   = in_px.pixel_in[15:8];
  assign b   = in_px.pixel_in[7:0];
  assign mx  = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
  assign mn  = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
  assign d   = mx - mn;
  assign dz  = (d == 8'd0);
  assign sum = {1'b0, mx} + {1'b0, mn};
  assign sden = (sum < 9'd255) ? sum : 9'd510 - sum;
  assign d6  = ({3'b0, d} << 2) + ({3'b0, d} << 1);

  always_comb begin
    if (r == mx) begin
      n0 = $signed({4'b0, g}) - $signed({4'b0, b});
    end else if (g == mx) begin
      n0 = $signed({3'b0, d, 1'b0}) + $signed({4'b0, b}) - $signed({4'b0, r});
    end else begin
      n0 = $signed({2'b0, d, 2'b0}) + $signed({4'b0, r}) - $signed({4'b0, g});
    end
    n1 = (n0 < 0) ? n0 + $signed({1'b0, d6}) : n0;
  end

  logic             f_v_r, f_dz_r;
  logic [7:0]       f_a_r;
  logic [8:0]       f_sum_r;
  logic [DIV_W-1:0] f_sa_r, f_sd_r, f_ha_r, f_hd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (en) begin
      f_v_r <= in_px.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_a_r   <= in_px.pixel_in[31:24];
      f_dz_r  <= dz;
      f_sa_r  <= {3'b0, d};
      f_sd_r  <= dz ? DIV_W'(1) : {2'b0, sden};
      f_ha_r  <= n1[DIV_W-1:0];
      f_hd_r  <= dz ? DIV_W'(1) : d6;
      f_sum_r <= sum;
    end
  end

  logic [QW-1:0] s_q, h_q, l_q;

  hts_div #(.DW(DIV_W), .QW(QW)) u_div_s (
    .clk, .en, .a(f_sa_r), .dv(f_sd_r), .q(s_q)
  );
  hts_div #(.DW(DIV_W), .QW(QW)) u_div_h (
    .clk, .en, .a(f_ha_r), .dv(f_hd_r), .q(h_q)
  );

  // side data alongside the divider stages
  logic       dv_v_r   [QW];
  logic       dv_dz_r  [QW];
  logic [7:0] dv_a_r   [QW];
  logic [8:0] dv_sum_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_side
    logic       v_nxt, dz_nxt;
    logic [7:0] a_nxt;
    logic [8:0] sum_nxt;
    if (i == 0) begin : g_first
      assign v_nxt   = f_v_r;
      assign dz_nxt  = f_dz_r;
      assign a_nxt   = f_a_r;
      assign sum_nxt = f_sum_r;
    end else begin : g_next
      assign v_nxt   = dv_v_r[i-1];
      assign dz_nxt  = dv_dz_r[i-1];
      assign a_nxt   = dv_a_r[i-1];
      assign sum_nxt = dv_sum_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[i] <= 1'b0;
      end else if (en) begin
        dv_v_r[i] <= v_nxt;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_dz_r[i]  <= dz_nxt;
        dv_a_r[i]   <= a_nxt;
        dv_sum_r[i] <= sum_nxt;
      end
    end
  end

  // l = sum / 510: split sum = 255*k + rem; rem/255 is rem repeated in binary
  logic [8:0]  l_sum;
  logic [1:0]  l_int;
  logic [7:0]  l_rem;
  logic [23:0] l_rep;

  assign l_sum = dv_sum_r[QW-1];

  always_comb begin
    if (l_sum < 9'd255) begin
      l_int = 2'd0;
      l_rem = l_sum[7:0];
    end else if (l_sum < 9'd510) begin
      l_int = 2'd1;
      l_rem = l_sum[7:0] + 8'd1;
    end else begin
      l_int = 2'd2;
      l_rem = 8'd0;
    end
  end

  assign l_rep = {3{l_rem}};
  assign l_q   = {l_int, l_rep[23 -: (FRAC_BITS-1)]};

  hts_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk,
    .rst_n,
    .en,
    .in_v  (dv_v_r[QW-1]),
    .h_q   (h_q),
    .s_q   (s_q),
    .l_q   (l_q),
    .dz    (dv_dz_r[QW-1]),
    .alpha (dv_a_r[QW-1]),
    .cfg,
    .out_v,
    .pixel (out_px.pixel_out)
  );

  assign out_px.valid = out_v;

endmodule
`default_nettype wire

/* bench/tb_hsl_tint_shift_pixel.sv */
`timescale 1ns / 100ps
module tb_hsl_tint_shift_pixel;
  import hts_pkg::*;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  hts_in_if  in_px();
  hts_out_if out_px();

  hsl_tint_shift_pixel dut (
    .clk(clk), .rst_n(rst_n), .in_px(in_px), .out_px(out_px),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  localparam longint ONE = 64'd1 << HTS_FRAC_BITS;
  localparam int LATENCY = HTS_FRAC_BITS + 11;

  logic [17:0] hue_reg, sat_reg, lit_reg;
  logic [31:0] pixel_queue[$];
  logic [31:0] expected_pixels[$];
  int errors;
  longint cycles;
  bit calm;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit decode_reg(input logic [17:0] raw, output longint v);
    if (raw[17]) return 1'b0;
    v = (raw > 18'd65536) ? 65536 : longint'(raw);
    v = (v << HTS_FRAC_BITS) >> 16;
    return 1'b1;
  endfunction

  function automatic longint hue_to_byte(input longint t1, t2, input longint x);
    longint v;
    if (x < 0) x += 3 * ONE;
    else if (x > 3 * ONE) x -= 3 * ONE;
    if (2 * x < ONE) v = t1 + (((t2 - t1) * (2 * x)) >>> HTS_FRAC_BITS);
    else if (2 * x < 3 * ONE) v = t2;
    else if (x < 2 * ONE) v = t1 + (((t2 - t1) * (4 * ONE - 2 * x)) >>> HTS_FRAC_BITS);
    else v = t1;
    if (v < 0) v = 0;
    if (v > ONE) v = ONE;
    return (v * 255) >> HTS_FRAC_BITS;
  endfunction

  function automatic logic [31:0] shift_pixel(input logic [31:0] px);
    longint r, g, b, mx, mn, d, n, h, s, l, sh, t1, t2, k;
    longint c[3];
    r = px[23:16]; g = px[15:8]; b = px[7:0];
    h = 0; s = 0;
    mx = (r > g) ? r : g; mx = (mx > b) ? mx : b;
    mn = (r < g) ? r : g; mn = (mn < b) ? mn : b;
    d = mx - mn;
    l = ((mx + mn) << HTS_FRAC_BITS) / 510;
    if (d != 0) begin
      if (mx + mn < 255) s = (d << HTS_FRAC_BITS) / (mx + mn);
      else s = (d << HTS_FRAC_BITS) / (510 - mx - mn);
      if (r == mx) n = g - b;
      else if (g == mx) n = 2 * d + b - r;
      else n = 4 * d + r - g;
      if (n < 0) n += 6 * d;
      h = (n << HTS_FRAC_BITS) / (6 * d);
    end
    if (decode_reg(hue_reg, sh)) h = sh;
    if (decode_reg(sat_reg, sh)) begin
      if (sh <= ONE / 2) s = (s * sh) >> (HTS_FRAC_BITS - 1);
      else s = s + (((ONE - s) * (2 * sh - ONE)) >> HTS_FRAC_BITS);
    end
    if (s == 0) begin
      k = (l * 256) >> HTS_FRAC_BITS;
      if (k > 255) k = 255;
      c[0] = k; c[1] = k; c[2] = k;
    end else begin
      if (l < ONE / 2) t2 = (l * (ONE + s)) >> HTS_FRAC_BITS;
      else t2 = l + s - ((l * s) >> HTS_FRAC_BITS);
      t1 = 2 * l - t2;
      c[0] = hue_to_byte(t1, t2, 3 * h + ONE);
      c[1] = hue_to_byte(t1, t2, 3 * h);
      c[2] = hue_to_byte(t1, t2, 3 * h - ONE);
    end
    if (decode_reg(lit_reg, sh)) begin
      for (int i = 0; i < 3; i++) begin
        if (sh <= ONE / 2) c[i] = (c[i] * sh) >> (HTS_FRAC_BITS - 1);
        else c[i] = c[i] + (((255 - c[i]) * (2 * sh - ONE)) >> HTS_FRAC_BITS);
      end
    end
    return {px[31:24], c[0][7:0], c[1][7:0], c[2][7:0]};
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [17:0] value);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= CFG_AW'(idx) << 2; pwdata <= {{14{value[17]}}, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_HUE: hue_reg = value;
      REG_SAT: sat_reg = value;
      REG_LIT: lit_reg = value;
      default: ;
    endcase
  endtask

  task automatic drain;
    while (pixel_queue.size() != 0 || expected_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [17:0] pick_reg();
    case ($urandom_range(0, 5))
      0: return 18'h3FFFF;
      1: return 18'd0;
      2: return 18'd65536;
      3: return 18'd32768;
      4: return 18'($urandom_range(65537, 131071));
      default: return 18'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [31:0] random_pixel();
    logic [7:0] v;
    v = 8'($urandom);
    case ($urandom_range(0, 4))
      0: return {8'($urandom), v, v, v};
      1: return {8'($urandom), v, 8'($urandom), v};
      default: return $urandom;
    endcase
  endfunction

  // driver
  int in_idle;
  bit in_taken;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_px.valid <= 1'b0;
      in_idle = 0;
      in_taken = 1'b0;
    end else if (!in_px.valid || in_taken) begin
      in_taken = 1'b0;
      if (in_idle > 0) begin
        in_idle--;
        in_px.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        in_idle = $urandom_range(0, 13);
        in_px.valid <= 1'b0;
      end else if (pixel_queue.size() != 0) begin
        in_px.valid <= 1'b1;
        in_px.pixel_in <= pixel_queue[0];
      end else begin
        in_px.valid <= 1'b0;
      end
    end
  end

  // acceptance is sampled at the rising edge so expectations use current registers
  always @(posedge clk) begin
    if (rst_n && in_px.valid && in_px.ready) begin
      expected_pixels.push_back(shift_pixel(in_px.pixel_in));
      void'(pixel_queue.pop_front());
      in_taken = 1'b1;
    end
  end

  int out_idle;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_px.ready <= 1'b0;
      out_idle = 0;
    end else if (out_idle > 0) begin
      out_idle--;
      out_px.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_idle = $urandom_range(0, 13);
      out_px.ready <= 1'b0;
    end else begin
      out_px.ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n && out_px.valid && out_px.ready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, out_px.pixel_out);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_px.pixel_out !== want) begin
          $display("%0t: pixel_out mismatch, expected %h, actual %h", $time, want,
                   out_px.pixel_out);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [31:0] edge_px[$];
    errors = 0; cycles = 0; calm = 0;
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_px.valid = 1'b0; in_px.pixel_in = '0; out_px.ready = 1'b0;
    hue_reg = 18'h3FFFF; sat_reg = 18'h3FFFF; lit_reg = 18'h3FFFF;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    edge_px = '{32'h00000000, 32'hFFFFFFFF, 32'h12FF0000, 32'h3400FF00, 32'h560000FF,
                32'h78FFFF00, 32'h9A00FFFF, 32'hBCFF00FF, 32'hDE808080, 32'h017F7F7F,
                32'hA5FF8000, 32'h5A0080FF, 32'h80FF0080, 32'h7F010203, 32'hFEFEFDFC};
    foreach (edge_px[i]) pixel_queue.push_back(edge_px[i]);
    drain();
    // disabled via other negatives, grey boost, saturation on range ends
    write_reg(REG_HUE, 18'h20000);
    write_reg(REG_SAT, 18'd65536);
    write_reg(REG_LIT, 18'd0);
    foreach (edge_px[i]) pixel_queue.push_back(edge_px[i]);
    drain();
    write_reg(REG_HUE, 18'd65536);
    write_reg(REG_SAT, 18'd131071);
    write_reg(REG_LIT, 18'd65536);
    foreach (edge_px[i]) pixel_queue.push_back(edge_px[i]);
    drain();
    write_reg(REG_HUE, 18'd0);
    write_reg(REG_SAT, 18'd0);
    write_reg(REG_LIT, 18'd32768);
    foreach (edge_px[i]) pixel_queue.push_back(edge_px[i]);
    drain();

    for (int phase = 0; phase < 10; phase++) begin
      write_reg(REG_HUE, pick_reg());
      write_reg(REG_SAT, pick_reg());
      write_reg(REG_LIT, pick_reg());
      if (phase == 9) calm = 1;
      for (int i = 0; i < 100; i++) pixel_queue.push_back(random_pixel());
      drain();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* hsl_tint_shift_pixel.f */
hdl/hts_pkg.sv
hdl/hts_in_if.sv
hdl/hts_out_if.sv
hdl/hts_cfg.sv
hdl/hts_div.sv
hdl/hts_back.sv
hdl/hsl_tint_shift_pixel.sv
bench/tb_hsl_tint_shift_pixel.sv
